/* sv/assert_macros.svh */
// assertion macros shared by the chunker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/brc_pkg.sv */
// shared constants and types of the range chunker
package brc_pkg;

    localparam int START_W   = 32;
    localparam int LEN_W     = 14;
    localparam int TAG_W     = 32;
    localparam int WORKER_W  = 7;
    localparam int CHUNK_CAP = 128;
    localparam int MAX_CHUNKS = 64;
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int DIV_CNT_W = $clog2(LEN_W);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [WORKER_W-1:0] WORKER_RESET = WORKER_W'(1);

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   count;
        logic [LEN_W-1:0]   base;
        logic [CNT_W-1:0]   extra;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* sv/brc_front.sv */
// front end: takes items, works out the chunk count and divides the length
`include "assert_macros.svh"

module brc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [brc_pkg::START_W-1:0]   range_start,
    input  logic [brc_pkg::LEN_W-1:0]     range_length,
    input  logic                          no_split,
    input  logic [brc_pkg::TAG_W-1:0]     item_tag,
    input  logic                          cfg_wr_en,
    input  logic [brc_pkg::WORKER_W-1:0]  cfg_wr_data,
    input  brc_pkg::q_status_t            q_status,
    output logic                          push,
    output brc_pkg::desc_t                push_desc
);

    localparam int EXT_W = brc_pkg::LEN_W + 1;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } front_state_t;

    front_state_t                      state_reg;
    logic [brc_pkg::WORKER_W-1:0]      worker_reg;
    logic [brc_pkg::START_W-1:0]       start_reg;
    logic [brc_pkg::TAG_W-1:0]         tag_reg;
    logic [brc_pkg::CNT_W-1:0]         div_reg;
    logic [brc_pkg::LEN_W-1:0]         quo_reg;
    logic [brc_pkg::CNT_W-1:0]         rem_reg;
    logic [brc_pkg::DIV_CNT_W-1:0]     step_reg;

    logic                              accept;
    logic [EXT_W-1:0]                  len_ext;
    logic [EXT_W-1:0]                  by_cap;
    logic [EXT_W-1:0]                  workers;
    logic [EXT_W-1:0]                  n_max;
    logic [EXT_W-1:0]                  n_len;
    logic [EXT_W-1:0]                  n_lim;
    logic                              trivial;
    logic [brc_pkg::CNT_W:0]           rem_shift;
    logic                              q_bit;
    logic [brc_pkg::CNT_W-1:0]         rem_next;
    logic [brc_pkg::LEN_W-1:0]         quo_next;
    logic                              div_done;

    assign busy   = (state_reg != F_IDLE) || q_status.full;
    assign accept = start && !busy;

    // chunk count: max(workers, ceil(len / cap)), limited to len and the chunk limit
    always_comb
    begin
        len_ext = {1'b0, range_length} + EXT_W'(brc_pkg::CHUNK_CAP - 1);
        by_cap  = EXT_W'(len_ext / brc_pkg::CHUNK_CAP);
        workers = (worker_reg == '0) ? EXT_W'(1) : EXT_W'(worker_reg);
        n_max   = (workers > by_cap) ? workers : by_cap;
        n_len   = (n_max > {1'b0, range_length}) ? {1'b0, range_length} : n_max;
        n_lim   = (n_len > EXT_W'(brc_pkg::MAX_CHUNKS)) ? EXT_W'(brc_pkg::MAX_CHUNKS) : n_len;
        trivial = no_split || (range_length <= brc_pkg::LEN_W'(1)) || (n_lim <= EXT_W'(1));
    end

    // one restoring divide step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[brc_pkg::LEN_W-1]};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        rem_next  = q_bit ? brc_pkg::CNT_W'(rem_shift - {1'b0, div_reg})
                          : brc_pkg::CNT_W'(rem_shift);
        quo_next  = {quo_reg[brc_pkg::LEN_W-2:0], q_bit};
        div_done  = (state_reg == F_DIV) && (step_reg == brc_pkg::DIV_CNT_W'(brc_pkg::LEN_W - 1));
    end

    always_comb
    begin
        push      = 1'b0;
        push_desc = '0;
        if (accept && trivial)
        begin
            push            = 1'b1;
            push_desc.start = range_start;
            push_desc.tag   = item_tag;
            push_desc.count = brc_pkg::CNT_W'(1);
            push_desc.base  = range_length;
            push_desc.extra = '0;
        end
        else if (div_done)
        begin
            push            = 1'b1;
            push_desc.start = start_reg;
            push_desc.tag   = tag_reg;
            push_desc.count = div_reg;
            push_desc.base  = quo_next;
            push_desc.extra = rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            worker_reg <= brc_pkg::WORKER_RESET;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                worker_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept && !trivial)
                    begin
                        state_reg <= F_DIV;
                        step_reg  <= '0;
                        start_reg <= range_start;
                        tag_reg   <= item_tag;
                        div_reg   <= brc_pkg::CNT_W'(n_lim);
                        quo_reg   <= range_length;
                        rem_reg   <= '0;
                    end
                end
                F_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (div_done)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && q_status.full, "push into full queue")

endmodule

/* sv/brc_queue.sv */
// small descriptor queue between front and back
`include "assert_macros.svh"

module brc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brc_pkg::desc_t      push_desc,
    input  logic                pop,
    output brc_pkg::desc_t      head,
    output brc_pkg::q_status_t  status
);

    brc_pkg::desc_t                entry_reg [brc_pkg::Q_DEPTH];
    logic [brc_pkg::Q_AW-1:0]      wr_ptr_reg;
    logic [brc_pkg::Q_AW-1:0]      rd_ptr_reg;
    logic [brc_pkg::Q_AW:0]        fill_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == (brc_pkg::Q_AW + 1)'(brc_pkg::Q_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && status.empty, "pop from empty queue")

endmodule

/* sv/brc_back.sv */
// back end: walks one descriptor and emits a chunk beat per cycle
`include "assert_macros.svh"

module brc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brc_pkg::desc_t                head,
    input  brc_pkg::q_status_t            q_status,
    output logic                          pop,
    output logic                          strobe,
    output logic [brc_pkg::START_W-1:0]   chunk_start,
    output logic [brc_pkg::LEN_W-1:0]     chunk_length,
    output logic [brc_pkg::TAG_W-1:0]     chunk_tag,
    output logic                          last_chunk
);

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

    back_state_t                   state_reg;
    logic [brc_pkg::START_W-1:0]   pos_reg;
    logic [brc_pkg::TAG_W-1:0]     tag_reg;
    logic [brc_pkg::CNT_W-1:0]     count_reg;
    logic [brc_pkg::LEN_W-1:0]     base_reg;
    logic [brc_pkg::CNT_W-1:0]     extra_reg;
    logic [brc_pkg::CNT_W-1:0]     idx_reg;
    logic                          strobe_reg;
    logic [brc_pkg::START_W-1:0]   chunk_start_reg;
    logic [brc_pkg::LEN_W-1:0]     chunk_length_reg;
    logic [brc_pkg::TAG_W-1:0]     chunk_tag_reg;
    logic                          last_reg;

    logic [brc_pkg::LEN_W-1:0]     clen;
    logic                          is_last;

    assign pop     = (state_reg == B_IDLE) && !q_status.empty;
    assign clen    = base_reg + brc_pkg::LEN_W'(idx_reg < extra_reg);
    assign is_last = (idx_reg == brc_pkg::CNT_W'(count_reg - 1'b1));

    assign strobe       = strobe_reg;
    assign chunk_start  = chunk_start_reg;
    assign chunk_length = chunk_length_reg;
    assign chunk_tag    = chunk_tag_reg;
    assign last_chunk   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= B_EMIT;
                        pos_reg   <= head.start;
                        tag_reg   <= head.tag;
                        count_reg <= head.count;
                        base_reg  <= head.base;
                        extra_reg <= head.extra;
                        idx_reg   <= '0;
                    end
                end
                B_EMIT:
                begin
                    strobe_reg       <= 1'b1;
                    chunk_start_reg  <= pos_reg;
                    chunk_length_reg <= clen;
                    chunk_tag_reg    <= tag_reg;
                    last_reg         <= is_last;
                    pos_reg          <= pos_reg + brc_pkg::START_W'(clen);
                    idx_reg          <= idx_reg + 1'b1;
                    if (is_last)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_chunks_back_to_back, clk, rst_n, strobe && !last_chunk, strobe, "gap in chunk run")

endmodule

/* sv/balanced_range_chunker.sv */
// balanced range chunker: splits a frame range into balanced chunks
// path: item -> divider (split items only) -> queue -> emitter -> output registers
// throughput: one chunk beat per cycle while emitting; a split item holds the divider
// the emitter pops in idle, then emits each chunk; a 2-entry queue overlaps them
// the receiver cannot stall; busy is high while dividing or while the queue is full
// async active-low reset clears control state and sets the worker register to 1
module balanced_range_chunker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [brc_pkg::START_W-1:0]   range_start,
    input  logic [brc_pkg::LEN_W-1:0]     range_length,
    input  logic                          no_split,
    input  logic [brc_pkg::TAG_W-1:0]     item_tag,
    input  logic                          cfg_wr_en,
    input  logic [brc_pkg::WORKER_W-1:0]  cfg_wr_data,
    output logic                          strobe,
    output logic [brc_pkg::START_W-1:0]   chunk_start,
    output logic [brc_pkg::LEN_W-1:0]     chunk_length,
    output logic [brc_pkg::TAG_W-1:0]     chunk_tag,
    output logic                          last_chunk
);

    logic                  push;
    logic                  pop;
    brc_pkg::desc_t        push_desc;
    brc_pkg::desc_t        head;
    brc_pkg::q_status_t    q_status;

    brc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .range_start  (range_start),
        .range_length (range_length),
        .no_split     (no_split),
        .item_tag     (item_tag),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_status     (q_status),
        .push         (push),
        .push_desc    (push_desc)
    );

    brc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    brc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .strobe       (strobe),
        .chunk_start  (chunk_start),
        .chunk_length (chunk_length),
        .chunk_tag    (chunk_tag),
        .last_chunk   (last_chunk)
    );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the balanced range chunker
`timescale 1ns / 100ps

module tb_top;

    localparam int             SETTLE_CYCLES = 24;
    localparam int             RANDOM_PHASES = 4;
    localparam int             ITEMS_PER_PHASE = 28;
    localparam logic [7:0]     SAME_WORKERS = 8'hFF;

    typedef struct packed {
        logic [7:0]                  workers;
        logic [brc_pkg::START_W-1:0] start;
        logic [brc_pkg::LEN_W-1:0]   len;
        logic                        keep;
        logic [brc_pkg::TAG_W-1:0]   tag;
        logic                        whole;
    } stim_row_t;

    typedef struct packed {
        logic [brc_pkg::START_W-1:0] start;
        logic [brc_pkg::LEN_W-1:0]   len;
        logic [brc_pkg::TAG_W-1:0]   tag;
        logic                        last;
    } chunk_t;

    localparam int DIRECTED_COUNT = 20;

    // whole = 1: item comes out unchanged as a single chunk
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{SAME_WORKERS, 32'h0000_0000, 14'd0,     1'b0, 32'h0000_0000, 1'b1},
        '{SAME_WORKERS, 32'hFFFF_FFFF, 14'd1,     1'b0, 32'hFFFF_FFFF, 1'b1},
        '{SAME_WORKERS, 32'h0000_1000, 14'd128,   1'b0, 32'h1234_5678, 1'b1},
        '{SAME_WORKERS, 32'h0000_1000, 14'd129,   1'b0, 32'h8765_4321, 1'b0},
        '{SAME_WORKERS, 32'h5555_AAAA, 14'd16383, 1'b1, 32'hAAAA_5555, 1'b1},
        '{SAME_WORKERS, 32'hFFFF_FF00, 14'd16383, 1'b0, 32'h0F0F_0F0F, 1'b0},
        '{SAME_WORKERS, 32'h0000_0000, 14'd8192,  1'b0, 32'hF0F0_F0F0, 1'b0},
        '{8'd0,         32'h0000_0010, 14'd100,   1'b0, 32'h0000_0001, 1'b1},
        '{SAME_WORKERS, 32'h0000_0010, 14'd300,   1'b0, 32'h0000_0002, 1'b0},
        '{8'd127,       32'hFFFF_FFFF, 14'd2,     1'b0, 32'h0000_0003, 1'b0},
        '{SAME_WORKERS, 32'h0000_0000, 14'd63,    1'b0, 32'h0000_0004, 1'b0},
        '{SAME_WORKERS, 32'h7FFF_FFF0, 14'd200,   1'b0, 32'h0000_0005, 1'b0},
        '{SAME_WORKERS, 32'h0000_0042, 14'd1,     1'b0, 32'h0000_0006, 1'b1},
        '{SAME_WORKERS, 32'h0000_0043, 14'd5,     1'b1, 32'hFFFF_FFFF, 1'b1},
        '{SAME_WORKERS, 32'h0000_0044, 14'd0,     1'b0, 32'h0000_0007, 1'b1},
        '{8'd64,        32'h0000_0100, 14'd65,    1'b0, 32'h0000_0008, 1'b0},
        '{SAME_WORKERS, 32'hFFFF_FFFF, 14'd16383, 1'b0, 32'h0000_0000, 1'b0},
        '{8'd2,         32'h0000_0000, 14'd3,     1'b0, 32'hDEAD_0001, 1'b0},
        '{SAME_WORKERS, 32'h0000_0000, 14'd0,     1'b0, 32'hDEAD_0002, 1'b1},
        '{SAME_WORKERS, 32'hFFFF_FFFE, 14'd8191,  1'b0, 32'hDEAD_0003, 1'b0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [brc_pkg::START_W-1:0]   range_start = '0;
    logic [brc_pkg::LEN_W-1:0]     range_length = '0;
    logic                          no_split = 1'b0;
    logic [brc_pkg::TAG_W-1:0]     item_tag = '0;
    logic                          cfg_wr_en = 1'b0;
    logic [brc_pkg::WORKER_W-1:0]  cfg_wr_data = '0;
    logic                          strobe;
    logic [brc_pkg::START_W-1:0]   chunk_start;
    logic [brc_pkg::LEN_W-1:0]     chunk_length;
    logic [brc_pkg::TAG_W-1:0]     chunk_tag;
    logic                          last_chunk;

    chunk_t                        pending_chunks [$];
    logic [brc_pkg::WORKER_W-1:0]  workers_model = brc_pkg::WORKER_RESET;
    int                            error_count = 0;
    int                            idle_pct = 0;

    balanced_range_chunker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .range_start  (range_start),
        .range_length (range_length),
        .no_split     (no_split),
        .item_tag     (item_tag),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .strobe       (strobe),
        .chunk_start  (chunk_start),
        .chunk_length (chunk_length),
        .chunk_tag    (chunk_tag),
        .last_chunk   (last_chunk)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // expected chunks of one accepted item, oldest first
    function automatic void split_range(input logic [brc_pkg::START_W-1:0] first,
                                        input logic [brc_pkg::LEN_W-1:0] len,
                                        input logic keep,
                                        input logic [brc_pkg::TAG_W-1:0] tag);
        int unsigned                 workers;
        int unsigned                 by_cap;
        int unsigned                 n;
        int unsigned                 base;
        int unsigned                 extra;
        int unsigned                 clen;
        logic [brc_pkg::START_W-1:0] pos;
        chunk_t                      c;
        workers = (workers_model == 0) ? 1 : workers_model;
        by_cap = (len + brc_pkg::CHUNK_CAP - 1) / brc_pkg::CHUNK_CAP;
        n = (workers > by_cap) ? workers : by_cap;
        if (n > len)
            n = len;
        if (n > brc_pkg::MAX_CHUNKS)
            n = brc_pkg::MAX_CHUNKS;
        if (keep || len <= 1)
            n = 1;
        if (n <= 1)
        begin
            c = '{first, len, tag, 1'b1};
            pending_chunks = {pending_chunks, c};
            return;
        end
        base = len / n;
        extra = len % n;
        pos = first;
        for (int unsigned i = 0; i < n; i++)
        begin
            clen = base + ((i < extra) ? 1 : 0);
            c = '{pos, clen[brc_pkg::LEN_W-1:0], tag, (i == n - 1)};
            pending_chunks = {pending_chunks, c};
            pos = pos + clen;
        end
    endfunction

    task automatic hold_off_sender();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic send_item(input logic [brc_pkg::START_W-1:0] first,
                             input logic [brc_pkg::LEN_W-1:0] len,
                             input logic keep,
                             input logic [brc_pkg::TAG_W-1:0] tag,
                             input logic whole);
        chunk_t c;
        @(negedge clk);
        start <= 1'b1;
        range_start <= first;
        range_length <= len;
        no_split <= keep;
        item_tag <= tag;
        do
            @(posedge clk);
        while (busy);
        if (whole)
        begin
            c = '{first, len, tag, 1'b1};
            pending_chunks = {pending_chunks, c};
        end
        else
            split_range(first, len, keep, tag);
    endtask

    task automatic wait_drained();
        hold_off_sender();
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_workers(input logic [brc_pkg::WORKER_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= brc_pkg::WORKER_W'($urandom);
        workers_model = value;
    endtask

    task automatic send_random_item();
        logic [brc_pkg::START_W-1:0] first;
        logic [brc_pkg::LEN_W-1:0]   len;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < 10)
            len = brc_pkg::LEN_W'($urandom_range(1, 0));
        else if (pick < 70)
            len = brc_pkg::LEN_W'($urandom_range(300, 2));
        else if (pick < 90)
            len = brc_pkg::LEN_W'($urandom_range(8192, 301));
        else
            len = brc_pkg::LEN_W'($urandom_range(16383, 0));
        first = $urandom;
        if ($urandom_range(99) < 15)
            first = 32'hFFFF_FFFF - $urandom_range(500, 0);
        send_item(first, len, ($urandom_range(99) < 12), $urandom, 1'b0);
    endtask

    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n && strobe)
        begin
            if (pending_chunks.size() == 0)
            begin
                $error("chunk with no item pending: start %h length %0d",
                       chunk_start, chunk_length);
                error_count++;
            end
            else
            begin
                want = pending_chunks[0];
                pending_chunks.delete(0);
                if (chunk_start !== want.start)
                begin
                    $error("chunk_start: expected %h, got %h", want.start, chunk_start);
                    error_count++;
                end
                if (chunk_length !== want.len)
                begin
                    $error("chunk_length: expected %0d, got %0d", want.len, chunk_length);
                    error_count++;
                end
                if (chunk_tag !== want.tag)
                begin
                    $error("chunk_tag: expected %h, got %h", want.tag, chunk_tag);
                    error_count++;
                end
                if (last_chunk !== want.last)
                begin
                    $error("last_chunk: expected %b, got %b", want.last, last_chunk);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        logic [brc_pkg::WORKER_W-1:0] phase_workers [RANDOM_PHASES];
        int                           phase_idle [RANDOM_PHASES];
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].workers != SAME_WORKERS)
            begin
                wait_drained();
                set_workers(DIRECTED_ROWS[i].workers[brc_pkg::WORKER_W-1:0]);
            end
            send_item(DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].len,
                      DIRECTED_ROWS[i].keep, DIRECTED_ROWS[i].tag,
                      DIRECTED_ROWS[i].whole);
        end

        // no idling, sender idle 58, receiver phase (cannot stall), sender idle 11
        phase_workers = '{brc_pkg::WORKER_W'($urandom_range(16, 2)), 7'd127, 7'd0,
                          brc_pkg::WORKER_W'($urandom_range(127, 0))};
        phase_idle = '{0, 58, 0, 11};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            set_workers(phase_workers[p]);
            idle_pct = phase_idle[p];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                while ($urandom_range(99) < idle_pct)
                    hold_off_sender();
                if ($urandom_range(19) == 0)
                    wait_drained();
                send_random_item();
            end
        end

        wait_drained();
        if (error_count == 0 && pending_chunks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
